// ===== src/multi_pattern_qgram_matcher_assert.svh =====
// Assertion macros for the multi-pattern q-gram matcher.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MULTI_PATTERN_QGRAM_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_QGRAM_MATCHER_ASSERT_SVH

// Check a property outside reset
`define MPQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every edge, reset included
`define MPQM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== src/mpqm_pkg.sv =====
// Shared types, constants and hash functions of the q-gram matcher.
// No dependencies.
package mpqm_pkg;

  localparam int unsigned MAX_PATTERNS_DEF    = 256;
  localparam int unsigned GRAM_INDEX_BITS_DEF = 12;
  localparam int unsigned PATTERN_LEN         = 8;
  localparam int unsigned GRAM_LEN            = 3;
  localparam int unsigned GRAM_COUNT          = PATTERN_LEN - GRAM_LEN + 1;
  localparam int unsigned BITMAP_ROW_BITS     = 12;
  localparam int unsigned BITMAP_ROWS         = 1 << BITMAP_ROW_BITS;
  localparam int unsigned BITMAP_ROW_W        = 16;
  localparam int unsigned FILTER_TEST_BIT     = 5;
  localparam logic [7:0]  FILTER_ONES         = 8'hff;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_TEXT  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ADD_BM,
    ST_ADD_BMW,
    ST_INS_RD,
    ST_INS_CMP,
    ST_GR_RD,
    ST_GR_WR,
    ST_TX_VEC,
    ST_VF_BM,
    ST_BS_RD,
    ST_BS_CMP,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_CMP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic sweep_start;
    logic sweep_step;
    logic add_bm_rd;
    logic add_bm_wr;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic gr_rd;
    logic gr_wr;
    logic add_done;
    logic vec_upd;
    logic vf_bm_rd;
    logic bs_rd;
    logic bs_upd;
    logic sc_init;
    logic sc_rd;
    logic sc_pat_rd;
    logic sc_next;
    logic set_hit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       sweep_last;
    logic       full;
    logic       pos_zero;
    logic       rd_hash_gt;
    logic       gi_last;
    logic       verify_go;
    logic       bm_bit;
    logic       lo_lt_hi;
    logic       k_lt_cnt;
    logic       rd_hash_eq;
    logic       pat_eq;
    logic       out_free;
  } sts_t;

  function automatic logic [31:0] word_hash(input logic [63:0] w);
    return w[63:32] ^ w[31:0];
  endfunction

  function automatic logic [15:0] fold16(input logic [31:0] h);
    return h[31:16] ^ h[15:0];
  endfunction

endpackage

// ===== src/mpqm_if.sv =====
// Channel interfaces of the q-gram matcher: request items in, result items out.
// Depends on mpqm_pkg.
interface mpqm_in_if import mpqm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] pattern_word;
  logic [7:0]  text_byte;
  logic        end_of_text;

  modport source (output valid, req_type, pattern_word, text_byte, end_of_text,
                  input ready);
  modport sink   (input valid, req_type, pattern_word, text_byte, end_of_text,
                  output ready);
endinterface

interface mpqm_out_if import mpqm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        match_here;
  logic [31:0] match_total;

  modport source (output valid, match_here, match_total, input ready);
  modport sink   (input valid, match_here, match_total, output ready);
endinterface

// ===== src/multi_pattern_qgram_matcher.sv =====
// Top level of the multi-pattern q-gram matcher: controller plus datapath.
// Depends on mpqm_pkg, mpqm_if, mpqm_ctrl, mpqm_datapath and the assert macros.
//
// Usage: request items arrive on in_i (clear tables, add an 8-byte pattern,
// or one text byte); every text byte gives one result item on out_o with
// the match flag for the 8-byte window ending there and the saturating
// match count of the current text. Clear and add items give no result.
// Timing: one item at a time. A text byte whose filter rejects goes from
// accept through the vector update to the output register; the next item may
// enter right after if the output slot is free. A candidate window adds a
// bitmap lookup, a binary search (a read and a compare state per step) and a
// scan of equal hashes (read, check, compare each), bounded by the single read
// port of the sorted-hash memory. An add sets its bitmap bit, shifts each
// larger sorted entry up (a read and a compare state each) and clears its
// grams' table bits. A clear sweeps the gram table and bitmap one row a cycle.
// Reset: the same clearing pass runs first; in_i is not ready during it.
// Stall: a result waits in the output register while the next item is
// accepted and worked on; that item's own result waits until the slot frees.
`include "multi_pattern_qgram_matcher_assert.svh"

module multi_pattern_qgram_matcher import mpqm_pkg::*; #(
  parameter int unsigned MAX_PATTERNS    = MAX_PATTERNS_DEF,
  parameter int unsigned GRAM_INDEX_BITS = GRAM_INDEX_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpqm_in_if.sink    in_i,
  mpqm_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  mpqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpqm_datapath #(
    .MAX_PATTERNS    (MAX_PATTERNS),
    .GRAM_INDEX_BITS (GRAM_INDEX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (in_i.req_type),
    .pattern_word_i (in_i.pattern_word),
    .text_byte_i    (in_i.text_byte),
    .end_of_text_i  (in_i.end_of_text),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .match_here_o   (out_o.match_here),
    .match_total_o  (out_o.match_total)
  );

  // Checks
  `MPQM_ASSERT(a_hit_counts, (out_o.valid && out_o.match_here) |-> (out_o.match_total != 32'd0), "match reported with zero count")
  `MPQM_ASSERT(a_clear_blocks, (in_i.valid && in_i.ready && in_i.req_type == REQ_CLEAR) |=> !in_i.ready, "item accepted during clearing pass")
  `MPQM_ASSERT(a_load_free, cmd.load_out |-> sts.out_free, "result loaded over a pending one")
  `MPQM_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule

// ===== src/mpqm_ctrl.sv =====
// Controller state machine of the q-gram matcher: sequences clear, add and
// text items over the datapath. Depends on mpqm_pkg.
module mpqm_ctrl import mpqm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.req == REQ_CLEAR) begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_SWEEP;
          end else if (sts_i.req == REQ_ADD) begin
            if (!sts_i.full) state_d = ST_ADD_BM;
          end else if (sts_i.req == REQ_TEXT) begin
            state_d = ST_TX_VEC;
          end
        end
      end
      ST_ADD_BM: begin
        cmd_o.add_bm_rd = 1'b1;
        state_d         = ST_ADD_BMW;
      end
      ST_ADD_BMW: begin
        cmd_o.add_bm_wr = 1'b1;
        state_d         = ST_INS_RD;
      end
      ST_INS_RD: begin
        if (sts_i.pos_zero) begin
          cmd_o.ins_place = 1'b1;
          state_d         = ST_GR_RD;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts_i.rd_hash_gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = ST_INS_RD;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d         = ST_GR_RD;
        end
      end
      ST_GR_RD: begin
        cmd_o.gr_rd = 1'b1;
        state_d     = ST_GR_WR;
      end
      ST_GR_WR: begin
        cmd_o.gr_wr = 1'b1;
        if (sts_i.gi_last) begin
          cmd_o.add_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_GR_RD;
        end
      end
      ST_TX_VEC: begin
        cmd_o.vec_upd = 1'b1;
        if (sts_i.verify_go) begin
          cmd_o.vf_bm_rd = 1'b1;
          state_d        = ST_VF_BM;
        end else if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_VF_BM: begin
        state_d = sts_i.bm_bit ? ST_BS_RD : ST_RESULT;
      end
      ST_BS_RD: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.bs_rd = 1'b1;
          state_d     = ST_BS_CMP;
        end else begin
          cmd_o.sc_init = 1'b1;
          state_d       = ST_SC_RD;
        end
      end
      ST_BS_CMP: begin
        cmd_o.bs_upd = 1'b1;
        state_d      = ST_BS_RD;
      end
      ST_SC_RD: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.sc_rd = 1'b1;
          state_d     = ST_SC_CHK;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_SC_CHK: begin
        if (sts_i.rd_hash_eq) begin
          cmd_o.sc_pat_rd = 1'b1;
          state_d         = ST_SC_CMP;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_SC_CMP: begin
        if (sts_i.pat_eq) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_RESULT;
        end else begin
          cmd_o.sc_next = 1'b1;
          state_d       = ST_SC_RD;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/mpqm_datapath.sv =====
// Datapath of the q-gram matcher: tables, text state, search registers and
// the output register. Depends on mpqm_pkg.
module mpqm_datapath import mpqm_pkg::*; #(
  parameter int unsigned MAX_PATTERNS    = MAX_PATTERNS_DEF,
  parameter int unsigned GRAM_INDEX_BITS = GRAM_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] pattern_word_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        match_here_o,
  output logic [31:0] match_total_o
);

  localparam int unsigned IW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned CW = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned GD = 1 << GRAM_INDEX_BITS;
  localparam int unsigned SW = (GRAM_INDEX_BITS > BITMAP_ROW_BITS) ?
                               GRAM_INDEX_BITS : BITMAP_ROW_BITS;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_PATTERNS);

  function automatic logic [GRAM_INDEX_BITS-1:0] gram_hash(
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    logic [23:0] g;
    logic [23:0] h;
    g = {b0, b1, b2};
    h = g ^ (g >> GRAM_INDEX_BITS) ^ (g >> (2 * GRAM_INDEX_BITS));
    return h[GRAM_INDEX_BITS-1:0];
  endfunction

  // Memories
  logic [7:0]                 gram_mem [GD];
  logic [BITMAP_ROW_W-1:0]    bm_mem   [BITMAP_ROWS];
  logic [63:0]                pat_mem  [MAX_PATTERNS];
  logic [31:0]                hash_mem [MAX_PATTERNS];
  logic [IW-1:0]              ord_mem  [MAX_PATTERNS];

  logic [7:0]              gram_rd_q;
  logic [BITMAP_ROW_W-1:0] bm_rd_q;
  logic [63:0]             pat_rd_q;
  logic [31:0]             hash_rd_q;
  logic [IW-1:0]           ord_rd_q;

  // Item and state registers
  logic [63:0]   pat_q;
  logic          eot_q;
  logic [63:0]   window_q;
  logic [3:0]    seen_q;
  logic [7:0]    vec_q;
  logic [31:0]   cnt_q;
  logic [CW-1:0] stored_q;
  logic [SW-1:0] sweep_q;
  logic [IW-1:0] pos_q;
  logic [2:0]    gi_q;
  logic [CW-1:0] lo_q, hi_q, k_q;
  logic          hit_q;
  logic          out_valid_q, out_hit_q;
  logic [31:0]   out_total_q;

  logic [63:0]                pat_sh;
  logic [GRAM_INDEX_BITS-1:0] gram_cap_addr, gram_add_addr, gram_raddr;
  logic [31:0]                h_pat, h_win;
  logic [15:0]                f_pat, f_win;
  logic [BITMAP_ROW_BITS-1:0] bm_raddr;
  logic [CW-1:0]              mid;
  logic [IW-1:0]              hash_raddr;
  logic [7:0]                 vec_new;
  logic [31:0]                cnt_nx;
  logic                       sweep_gram_en, sweep_bm_en, out_free;

  // Address and hash logic
  always_comb begin
    pat_sh        = pat_q << {gi_q, 3'b000};
    gram_cap_addr = gram_hash(window_q[15:8], window_q[7:0], text_byte_i);
    gram_add_addr = gram_hash(pat_sh[63:56], pat_sh[55:48], pat_sh[47:40]);
    gram_raddr    = cmd_i.capture ? gram_cap_addr : gram_add_addr;
    h_pat         = word_hash(pat_q);
    h_win         = word_hash(window_q);
    f_pat         = fold16(h_pat);
    f_win         = fold16(h_win);
    bm_raddr      = cmd_i.add_bm_rd ? f_pat[15:4] : f_win[15:4];
    mid           = lo_q + ((hi_q - lo_q) >> 1);
    if (cmd_i.ins_rd) begin
      hash_raddr = pos_q - IW'(1);
    end else if (cmd_i.bs_rd) begin
      hash_raddr = mid[IW-1:0];
    end else begin
      hash_raddr = k_q[IW-1:0];
    end
    sweep_gram_en = (sweep_q >> GRAM_INDEX_BITS) == '0;
    sweep_bm_en   = (sweep_q >> BITMAP_ROW_BITS) == '0;
    vec_new       = (seen_q >= 4'(GRAM_LEN)) ? ({vec_q[6:0], 1'b0} | gram_rd_q) : vec_q;
    cnt_nx        = (hit_q && (cnt_q != '1)) ? cnt_q + 32'd1 : cnt_q;
    out_free      = !out_valid_q || out_ready_i;
  end

  // Gram mask table: clear to ones, or clear one offset bit of an entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step && sweep_gram_en) begin
      gram_mem[sweep_q[GRAM_INDEX_BITS-1:0]] <= FILTER_ONES;
    end else if (cmd_i.gr_wr) begin
      gram_mem[gram_add_addr] <= gram_rd_q & ~(8'd1 << gi_q);
    end
    gram_rd_q <= gram_mem[gram_raddr];
  end

  // Hash bitmap: clear to zero, or set the pattern's bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step && sweep_bm_en) begin
      bm_mem[sweep_q[BITMAP_ROW_BITS-1:0]] <= '0;
    end else if (cmd_i.add_bm_wr) begin
      bm_mem[f_pat[15:4]] <= bm_rd_q | (BITMAP_ROW_W'(1) << f_pat[3:0]);
    end
    bm_rd_q <= bm_mem[bm_raddr];
  end

  // Pattern store
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_bm_rd) begin
      pat_mem[stored_q[IW-1:0]] <= pat_q;
    end
    pat_rd_q <= pat_mem[ord_rd_q];
  end

  // Sorted hashes and their slots
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_shift) begin
      hash_mem[pos_q] <= hash_rd_q;
      ord_mem[pos_q]  <= ord_rd_q;
    end else if (cmd_i.ins_place) begin
      hash_mem[pos_q] <= h_pat;
      ord_mem[pos_q]  <= stored_q[IW-1:0];
    end
    if (cmd_i.ins_rd || cmd_i.bs_rd || cmd_i.sc_rd) begin
      hash_rd_q <= hash_mem[hash_raddr];
      ord_rd_q  <= ord_mem[hash_raddr];
    end
  end

  // Item capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pat_q <= pattern_word_i;
      eot_q <= end_of_text_i;
      pos_q <= stored_q[IW-1:0];
    end else if (cmd_i.ins_shift) begin
      pos_q <= pos_q - IW'(1);
    end
    if (cmd_i.ins_place) begin
      gi_q <= '0;
    end else if (cmd_i.gr_wr) begin
      gi_q <= gi_q + 3'd1;
    end
    if (cmd_i.vf_bm_rd) begin
      lo_q <= '0;
      hi_q <= stored_q;
    end else if (cmd_i.bs_upd) begin
      if (hash_rd_q < h_win) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.sc_init) begin
      k_q <= lo_q;
    end else if (cmd_i.sc_next) begin
      k_q <= k_q + CW'(1);
    end
  end

  // Control state: tables, text and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      seen_q      <= '0;
      vec_q       <= FILTER_ONES;
      cnt_q       <= '0;
      stored_q    <= '0;
      sweep_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_total_q <= '0;
    end else begin
      if (cmd_i.sweep_start) begin
        sweep_q  <= '0;
        stored_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + SW'(1);
      end
      if (cmd_i.add_done) stored_q <= stored_q + CW'(1);
      if (cmd_i.capture) begin
        hit_q <= 1'b0;
        if (req_type_i == REQ_TEXT) begin
          window_q <= {window_q[55:0], text_byte_i};
          if (seen_q < 4'(PATTERN_LEN)) seen_q <= seen_q + 4'd1;
        end
      end
      if (cmd_i.set_hit) hit_q <= 1'b1;
      // Restart the text after its last byte, else advance vector and count
      if (cmd_i.load_out && eot_q) begin
        window_q <= '0;
        seen_q   <= '0;
        vec_q    <= FILTER_ONES;
        cnt_q    <= '0;
      end else begin
        if (cmd_i.vec_upd) vec_q <= vec_new;
        if (cmd_i.load_out) cnt_q <= cnt_nx;
      end
      // Hand off the result; drop it when taken
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        out_hit_q   <= hit_q;
        out_total_q <= cnt_nx;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    sts_o.req        = req_type_i;
    sts_o.sweep_last = sweep_q == '1;
    sts_o.full       = stored_q >= MaxCount;
    sts_o.pos_zero   = pos_q == '0;
    sts_o.rd_hash_gt = hash_rd_q > h_pat;
    sts_o.gi_last    = gi_q == 3'(GRAM_COUNT - 1);
    sts_o.verify_go  = (seen_q >= 4'(PATTERN_LEN)) && !vec_new[FILTER_TEST_BIT];
    sts_o.bm_bit     = bm_rd_q[f_win[3:0]];
    sts_o.lo_lt_hi   = lo_q < hi_q;
    sts_o.k_lt_cnt   = k_q < stored_q;
    sts_o.rd_hash_eq = hash_rd_q == h_win;
    sts_o.pat_eq     = pat_rd_q == window_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign match_here_o  = out_hit_q;
  assign match_total_o = out_total_q;

endmodule
